FILE: hdl/pfn_pkg.sv
package pfn_pkg;

    localparam int GRID_BITS = 2;
    localparam int FREQ_W    = 31;
    localparam int AMP_W     = 17;
    localparam int SUM_W     = 39;
    localparam int TOT_W     = 20;
    localparam int OCT_W     = 4;
    localparam int QUO_W     = 18;
    localparam int NORM_W    = QUO_W + 1;
    localparam int POS_W     = 42;
    localparam int HALF_W    = POS_W / 2;
    localparam int FRAC_W    = 16;
    localparam int CFG_W     = 48;
    localparam int OUT_W     = 16;

    localparam logic [FREQ_W-1:0] FREQ_ONE = FREQ_W'(65536);
    localparam logic [AMP_W-1:0]  AMP_ONE  = AMP_W'(65536);
    localparam logic [10:0]       LAC_MAX  = 11'd1024;
    localparam logic signed [17:0] G_ONE   = 18'sd65536;
    localparam logic signed [17:0] G_DIAG  = 18'sd46341;

    typedef enum logic [2:0] {
        CFG_GRAD   = 3'd0,
        CFG_SCALE  = 3'd1,
        CFG_OCT    = 3'd2,
        CFG_PERS   = 3'd3,
        CFG_LAC    = 3'd4,
        CFG_GAIN   = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        DIR_E  = 3'd0,
        DIR_NE = 3'd1,
        DIR_N  = 3'd2,
        DIR_NW = 3'd3,
        DIR_W  = 3'd4,
        DIR_SW = 3'd5,
        DIR_S  = 3'd6,
        DIR_SE = 3'd7
    } t_dir;

    typedef struct packed {
        logic [CFG_W-1:0] grad_tbl;
        logic [23:0]      coord_scale;
        logic [OCT_W-1:0] octaves;
        logic [15:0]      persistence;
        logic [10:0]      lacunarity;
        logic [12:0]      gain;
    } t_cfg;

    typedef struct packed {
        logic [FREQ_W-1:0]        freq;
        logic [AMP_W-1:0]         amp;
        logic signed [SUM_W-1:0]  sum;
        logic [TOT_W-1:0]         total;
        logic [OCT_W-1:0]         octs;
    } t_acc;

    function automatic t_dir grad_code(input logic [CFG_W-1:0] tbl,
                                       input logic [GRID_BITS-1:0] row,
                                       input logic [GRID_BITS-1:0] col);
        return t_dir'(tbl[{row, col} * 3 +: 3]);
    endfunction

    function automatic logic signed [17:0] grad_x(input t_dir code);
        logic signed [17:0] g;
        unique case (code)
            DIR_E:  g = G_ONE;
            DIR_NE: g = G_DIAG;
            DIR_N:  g = '0;
            DIR_NW: g = -G_DIAG;
            DIR_W:  g = -G_ONE;
            DIR_SW: g = -G_DIAG;
            DIR_S:  g = '0;
            default: g = G_DIAG;
        endcase
        return g;
    endfunction

    function automatic logic signed [17:0] grad_y(input t_dir code);
        logic signed [17:0] g;
        unique case (code)
            DIR_E:  g = '0;
            DIR_NE: g = G_DIAG;
            DIR_N:  g = G_ONE;
            DIR_NW: g = G_DIAG;
            DIR_W:  g = '0;
            DIR_SW: g = -G_DIAG;
            DIR_S:  g = -G_ONE;
            default: g = -G_DIAG;
        endcase
        return g;
    endfunction

endpackage

FILE: hdl/pfn_octave.sv
module pfn_octave #(
    parameter int COORD_BITS = 10,
    parameter int OCT_IDX    = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  pfn_pkg::t_cfg         i_cfg,
    input  logic                  i_valid,
    input  logic [COORD_BITS-1:0] i_px,
    input  logic [COORD_BITS-1:0] i_py,
    input  pfn_pkg::t_acc         i_acc,
    output logic                  o_valid,
    output logic [COORD_BITS-1:0] o_px,
    output logic [COORD_BITS-1:0] o_py,
    output pfn_pkg::t_acc         o_acc
);

    localparam int NST = 12;
    localparam int PW  = pfn_pkg::POS_W;
    localparam int HW  = pfn_pkg::HALF_W;
    localparam int FW  = pfn_pkg::FRAC_W;

    logic                  r_v   [NST];
    logic [COORD_BITS-1:0] r_px  [NST];
    logic [COORD_BITS-1:0] r_py  [NST];
    pfn_pkg::t_acc         r_acc [NST];

    // lattice position
    logic [PW-1:0] r1_xp, r1_yp;
    logic [PW-1:0] r2_xl, r2_yl;
    logic [HW-1:0] r2_xh, r2_yh;
    logic [PW-1:0] n_xh, n_yh, n_xs, n_ys;
    logic [pfn_pkg::GRID_BITS-1:0] r3_cx, r3_cy;
    logic [FW-1:0] r3_lx, r3_ly;

    // corners and fade
    pfn_pkg::t_dir r4_code [4];
    logic [FW-1:0] r4_lx, r4_ly;
    logic [FW-1:0] r4_t2u, r4_t2v;
    logic signed [21:0] r4_iu, r4_iv;
    logic signed [21:0] n_au, n_av;
    logic signed [39:0] n_bu, n_bv;
    logic [31:0] n_sqx, n_sqy;
    logic signed [17:0] n_dx [4];
    logic signed [17:0] n_dy [4];

    logic signed [35:0] r5_gx [4];
    logic signed [35:0] r5_gy [4];
    logic [FW-1:0] r5_t3u, r5_t3v;
    logic signed [21:0] r5_iu, r5_iv;
    logic [31:0] n_cbx, n_cby;

    logic signed [17:0] r6_d [4];
    logic [16:0] r6_u, r6_v;
    logic signed [37:0] n_fu, n_fv;
    logic signed [21:0] n_su, n_sv;
    logic [16:0] n_u, n_v;

    // interpolation and weighting
    logic signed [36:0] r7_pa, r7_pb;
    logic signed [17:0] r7_d00, r7_d01;
    logic [16:0] r7_v;
    logic signed [18:0] r8_ab, r8_cd;
    logic [16:0] r8_v;
    logic signed [37:0] r9_p;
    logic signed [18:0] r9_ab;
    logic signed [18:0] r10_n;
    logic signed [36:0] r11_w;
    logic [pfn_pkg::FREQ_W-1:0] r11_fnx;
    logic [pfn_pkg::AMP_W-1:0]  r11_anx;
    logic [41:0] n_fprod;
    logic [32:0] n_aprod;
    logic        n_act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NST; s++) r_v[s] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s < NST; s++) r_v[s] <= r_v[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_px[0]  <= i_px;
            r_py[0]  <= i_py;
            for (int s = 1; s < NST; s++) begin
                r_px[s] <= r_px[s-1];
                r_py[s] <= r_py[s-1];
            end
        end
    end

    always_comb begin
        n_xh  = PW'(r1_xp[PW-1:HW]) * PW'(i_cfg.coord_scale);
        n_yh  = PW'(r1_yp[PW-1:HW]) * PW'(i_cfg.coord_scale);
        n_xs  = r2_xl + {r2_xh, {HW{1'b0}}};
        n_ys  = r2_yl + {r2_yh, {HW{1'b0}}};
        n_sqx = 32'(r3_lx) * 32'(r3_lx);
        n_sqy = 32'(r3_ly) * 32'(r3_ly);
        n_au  = signed'(22'(r3_lx) * 22'd6) - 22'sd983040;
        n_av  = signed'(22'(r3_ly) * 22'd6) - 22'sd983040;
        n_bu  = 40'(n_au) * 40'($signed({1'b0, r3_lx}));
        n_bv  = 40'(n_av) * 40'($signed({1'b0, r3_ly}));
        n_dx[0] = $signed({2'b00, r4_lx});
        n_dy[0] = $signed({2'b00, r4_ly});
        n_dx[1] = $signed({2'b11, r4_lx});
        n_dy[1] = $signed({2'b00, r4_ly});
        n_dx[2] = $signed({2'b00, r4_lx});
        n_dy[2] = $signed({2'b11, r4_ly});
        n_dx[3] = $signed({2'b11, r4_lx});
        n_dy[3] = $signed({2'b11, r4_ly});
        n_cbx = 32'(r4_t2u) * 32'(r4_lx);
        n_cby = 32'(r4_t2v) * 32'(r4_ly);
        n_fu  = 38'($signed({1'b0, r5_t3u})) * 38'(r5_iu);
        n_fv  = 38'($signed({1'b0, r5_t3v})) * 38'(r5_iv);
        n_su  = 22'(n_fu >>> 16);
        n_sv  = 22'(n_fv >>> 16);
        if (n_su < 0)                n_u = '0;
        else if (n_su > 22'sd65536)  n_u = 17'd65536;
        else                         n_u = n_su[16:0];
        if (n_sv < 0)                n_v = '0;
        else if (n_sv > 22'sd65536)  n_v = 17'd65536;
        else                         n_v = n_sv[16:0];
        n_fprod = 42'(r_acc[9].freq) * 42'(i_cfg.lacunarity);
        n_aprod = 33'(r_acc[9].amp) * 33'(i_cfg.persistence);
        n_act   = pfn_pkg::OCT_W'(OCT_IDX) < r_acc[10].octs;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc[0] <= i_acc;
            for (int s = 1; s < NST - 1; s++) r_acc[s] <= r_acc[s-1];

            r1_xp <= PW'(i_px) * PW'(i_acc.freq);
            r1_yp <= PW'(i_py) * PW'(i_acc.freq);

            r2_xl <= PW'(r1_xp[HW-1:0]) * PW'(i_cfg.coord_scale);
            r2_yl <= PW'(r1_yp[HW-1:0]) * PW'(i_cfg.coord_scale);
            r2_xh <= n_xh[HW-1:0];
            r2_yh <= n_yh[HW-1:0];

            r3_cx <= n_xs[PW-1:PW-2];
            r3_cy <= n_ys[PW-1:PW-2];
            r3_lx <= n_xs[PW-3:PW-2-FW];
            r3_ly <= n_ys[PW-3:PW-2-FW];

            r4_code[0] <= pfn_pkg::grad_code(i_cfg.grad_tbl, r3_cy, r3_cx);
            r4_code[1] <= pfn_pkg::grad_code(i_cfg.grad_tbl, r3_cy, r3_cx + 1'b1);
            r4_code[2] <= pfn_pkg::grad_code(i_cfg.grad_tbl, r3_cy + 1'b1, r3_cx);
            r4_code[3] <= pfn_pkg::grad_code(i_cfg.grad_tbl, r3_cy + 1'b1,
                                             r3_cx + 1'b1);
            r4_lx  <= r3_lx;
            r4_ly  <= r3_ly;
            r4_t2u <= n_sqx[31:16];
            r4_t2v <= n_sqy[31:16];
            r4_iu  <= 22'(n_bu >>> 16) + 22'sd655360;
            r4_iv  <= 22'(n_bv >>> 16) + 22'sd655360;

            for (int c = 0; c < 4; c++) begin
                r5_gx[c] <= 36'(pfn_pkg::grad_x(r4_code[c])) * 36'(n_dx[c]);
                r5_gy[c] <= 36'(pfn_pkg::grad_y(r4_code[c])) * 36'(n_dy[c]);
            end
            r5_t3u <= n_cbx[31:16];
            r5_t3v <= n_cby[31:16];
            r5_iu  <= r4_iu;
            r5_iv  <= r4_iv;

            for (int c = 0; c < 4; c++) begin
                r6_d[c] <= 18'((37'(r5_gx[c]) + 37'(r5_gy[c])) >>> 16);
            end
            r6_u <= n_u;
            r6_v <= n_v;

            r7_pa  <= 37'(19'(r6_d[1]) - 19'(r6_d[0])) * 37'($signed({1'b0, r6_u}));
            r7_pb  <= 37'(19'(r6_d[3]) - 19'(r6_d[2])) * 37'($signed({1'b0, r6_u}));
            r7_d00 <= r6_d[0];
            r7_d01 <= r6_d[2];
            r7_v   <= r6_v;

            r8_ab <= 19'(r7_d00) + 19'(r7_pa >>> 16);
            r8_cd <= 19'(r7_d01) + 19'(r7_pb >>> 16);
            r8_v  <= r7_v;

            r9_p  <= 38'(20'(r8_cd) - 20'(r8_ab)) * 38'($signed({1'b0, r8_v}));
            r9_ab <= r8_ab;

            r10_n <= r9_ab + 19'(r9_p >>> 16);

            r11_w   <= 37'(r10_n) * 37'($signed({1'b0, r_acc[9].amp}));
            r11_fnx <= n_fprod[pfn_pkg::FREQ_W+7:8];
            r11_anx <= n_aprod[pfn_pkg::AMP_W+15:16];

            r_acc[NST-1].freq  <= r11_fnx;
            r_acc[NST-1].amp   <= r11_anx;
            r_acc[NST-1].octs  <= r_acc[10].octs;
            r_acc[NST-1].sum   <= n_act ? r_acc[10].sum + pfn_pkg::SUM_W'(r11_w)
                                        : r_acc[10].sum;
            r_acc[NST-1].total <= n_act ? r_acc[10].total
                                          + pfn_pkg::TOT_W'(r_acc[10].amp)
                                        : r_acc[10].total;
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_px    = r_px[NST-1];
    assign o_py    = r_py[NST-1];
    assign o_acc   = r_acc[NST-1];

endmodule

FILE: hdl/pfn_div.sv
module pfn_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic signed [pfn_pkg::SUM_W-1:0]      i_sum,
    input  logic [pfn_pkg::TOT_W-1:0]             i_total,
    output logic                                  o_valid,
    output logic signed [pfn_pkg::NORM_W-1:0]     o_norm
);

    localparam int QW = pfn_pkg::QUO_W;
    localparam int MW = pfn_pkg::SUM_W;

    logic                        r_v   [QW+1];
    logic [MW-1:0]               r_mag [QW+1];
    logic [QW-1:0]               r_q   [QW+1];
    logic                        r_neg [QW+1];
    logic [pfn_pkg::TOT_W-1:0]   r_den [QW+1];
    logic [MW:0]                 n_trial [QW];
    logic [QW-1:0]               n_q     [QW];
    logic                        r_ov;
    logic signed [pfn_pkg::NORM_W-1:0] r_norm;

    always_comb begin
        for (int j = 0; j < QW; j++) begin
            n_trial[j] = {1'b0, r_mag[j]} - ((MW+1)'(r_den[j]) << (QW - 1 - j));
            n_q[j]     = r_q[j] | (QW'(!n_trial[j][MW]) << (QW - 1 - j));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QW; s++) r_v[s] <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int s = 1; s <= QW; s++) r_v[s] <= r_v[s-1];
            r_ov <= r_v[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag[0] <= i_sum[MW-1] ? MW'(-i_sum) : MW'(i_sum);
            r_neg[0] <= i_sum[MW-1];
            r_den[0] <= i_total;
            r_q[0]   <= '0;
            for (int j = 0; j < QW; j++) begin
                r_mag[j+1] <= n_trial[j][MW] ? r_mag[j] : n_trial[j][MW-1:0];
                r_q[j+1]   <= n_q[j];
                r_neg[j+1] <= r_neg[j];
                r_den[j+1] <= r_den[j];
            end
            r_norm <= r_neg[QW] ? -$signed({1'b0, r_q[QW]}) : $signed({1'b0, r_q[QW]});
        end
    end

    assign o_valid = r_ov;
    assign o_norm  = r_norm;

endmodule

FILE: hdl/perlin_fractal_noise_2d.sv
// Fractal 2D gradient noise: one pixel (x in the low tdata bits, y above) in, one
// signed Q1.15 noise value out. A new pixel is taken every cycle while the output is
// not stalled; each pixel passes through twelve stages per octave, twenty in the
// one-bit-per-stage divider that normalizes by the total amplitude, and two for gain and
// saturation. Every octave stage is always traversed; octave_count only decides which
// octaves add to the sum. Write configuration only while no pixel is in flight.
module perlin_fractal_noise_2d #(
    parameter int MAX_OCTAVES = 8,
    parameter int COORD_BITS  = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // pixel_x, pixel_y, zero fill
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // noise_value
    output logic [15:0] o_m_tdata,
    input  logic        i_cfg_wen,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data
);

    logic [47:0] r_grad_tbl;
    logic [23:0] r_coord_scale;
    logic [3:0]  r_octaves;
    logic [15:0] r_persist;
    logic [10:0] r_lacun;
    logic [12:0] r_gain;
    pfn_pkg::t_cfg n_cfg;
    logic        n_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grad_tbl    <= '0;
            r_coord_scale <= 24'd49152;
            r_octaves     <= 4'd8;
            r_persist     <= 16'd32768;
            r_lacun       <= 11'd512;
            r_gain        <= 13'd256;
        end else if (i_cfg_wen) begin
            unique case (i_cfg_idx)
                pfn_pkg::CFG_GRAD:  r_grad_tbl    <= i_cfg_data;
                pfn_pkg::CFG_SCALE: r_coord_scale <= i_cfg_data[23:0];
                pfn_pkg::CFG_OCT:   r_octaves     <= i_cfg_data[3:0];
                pfn_pkg::CFG_PERS:  r_persist     <= i_cfg_data[15:0];
                pfn_pkg::CFG_LAC:   r_lacun       <= i_cfg_data[10:0];
                pfn_pkg::CFG_GAIN:  r_gain        <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_cfg.grad_tbl    = r_grad_tbl;
        n_cfg.coord_scale = r_coord_scale;
        n_cfg.persistence = r_persist;
        n_cfg.gain        = r_gain;
        n_cfg.lacunarity  = (r_lacun > pfn_pkg::LAC_MAX) ? pfn_pkg::LAC_MAX : r_lacun;
        if (r_octaves == '0)
            n_cfg.octaves = 4'd1;
        else if (r_octaves > 4'(MAX_OCTAVES))
            n_cfg.octaves = 4'(MAX_OCTAVES);
        else
            n_cfg.octaves = r_octaves;
    end

    // hold the whole pipeline while a finished value waits
    assign n_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = n_en;

    logic                  w_v   [MAX_OCTAVES+1];
    logic [COORD_BITS-1:0] w_px  [MAX_OCTAVES+1];
    logic [COORD_BITS-1:0] w_py  [MAX_OCTAVES+1];
    pfn_pkg::t_acc         w_acc [MAX_OCTAVES+1];

    always_comb begin
        w_v[0]         = i_s_tvalid;
        w_px[0]        = i_s_tdata[COORD_BITS-1:0];
        w_py[0]        = i_s_tdata[2*COORD_BITS-1:COORD_BITS];
        w_acc[0].freq  = pfn_pkg::FREQ_ONE;
        w_acc[0].amp   = pfn_pkg::AMP_ONE;
        w_acc[0].sum   = '0;
        w_acc[0].total = '0;
        w_acc[0].octs  = n_cfg.octaves;
    end

    for (genvar k = 0; k < MAX_OCTAVES; k++) begin : g_oct
        pfn_octave #(
            .COORD_BITS (COORD_BITS),
            .OCT_IDX    (k)
        ) u_oct (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (n_en),
            .i_cfg   (n_cfg),
            .i_valid (w_v[k]),
            .i_px    (w_px[k]),
            .i_py    (w_py[k]),
            .i_acc   (w_acc[k]),
            .o_valid (w_v[k+1]),
            .o_px    (w_px[k+1]),
            .o_py    (w_py[k+1]),
            .o_acc   (w_acc[k+1])
        );
    end

    logic                                 w_dv;
    logic signed [pfn_pkg::NORM_W-1:0]    w_norm;

    pfn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (n_en),
        .i_valid (w_v[MAX_OCTAVES]),
        .i_sum   (w_acc[MAX_OCTAVES].sum),
        .i_total (w_acc[MAX_OCTAVES].total),
        .o_valid (w_dv),
        .o_norm  (w_norm)
    );

    logic               r_pv;
    logic signed [32:0] r_prod;
    logic signed [23:0] n_sh;
    logic [15:0]        n_sat;
    logic               r_out_v;
    logic [15:0]        r_out_data;

    always_comb begin
        n_sh = 24'(r_prod >>> 9);
        if (n_sh > 24'sd32767)
            n_sat = 16'h7FFF;
        else if (n_sh < -24'sd32768)
            n_sat = 16'h8000;
        else
            n_sat = n_sh[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (n_en) begin
            r_pv    <= w_dv;
            r_out_v <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_prod     <= 33'(w_norm) * 33'($signed({1'b0, n_cfg.gain}));
            r_out_data <= n_sat;
        end
    end

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = r_out_data;

endmodule

FILE: hdl/pfn_checker.sv
module pfn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input blocked with empty output");

    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input taken while pipeline held");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result present after reset");

endmodule

bind perlin_fractal_noise_2d pfn_checker u_pfn_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

FILE: bench/noise_checker.sv
module noise_checker
    import pfn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // pixel_x, pixel_y, zero fill
    input  logic [23:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // noise_value
    input  logic [15:0] i_m_tdata,
    input  logic        i_cfg_wen,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint Q_ONE  = 65536;
    localparam longint Q_DIAG = 46341;

    logic [47:0] grad_tbl;
    logic [23:0] scale;
    logic [3:0]  octaves;
    logic [15:0] persist;
    logic [10:0] lacun;
    logic [12:0] gain;

    logic signed [15:0] noise_fifo[$];

    function automatic longint corner_dot(input t_dir code, input longint dx,
                                          input longint dy);
        longint gx;
        longint gy;
        case (code)
            DIR_E:   begin gx = Q_ONE;   gy = 0;       end
            DIR_NE:  begin gx = Q_DIAG;  gy = Q_DIAG;  end
            DIR_N:   begin gx = 0;       gy = Q_ONE;   end
            DIR_NW:  begin gx = -Q_DIAG; gy = Q_DIAG;  end
            DIR_W:   begin gx = -Q_ONE;  gy = 0;       end
            DIR_SW:  begin gx = -Q_DIAG; gy = -Q_DIAG; end
            DIR_S:   begin gx = 0;       gy = -Q_ONE;  end
            default: begin gx = Q_DIAG;  gy = -Q_DIAG; end
        endcase
        return (gx * dx + gy * dy) >>> 16;
    endfunction

    function automatic longint quintic(input longint t);
        longint t2;
        longint t3;
        longint inner;
        longint f;
        t2 = (t * t) >>> 16;
        t3 = (t2 * t) >>> 16;
        inner = (((6 * t - 15 * Q_ONE) * t) >>> 16) + 10 * Q_ONE;
        f = (t3 * inner) >>> 16;
        if (f < 0) f = 0;
        if (f > Q_ONE) f = Q_ONE;
        return f;
    endfunction

    function automatic longint blend(input longint a, input longint b, input longint f);
        return a + (((b - a) * f) >>> 16);
    endfunction

    function automatic longint cell_pos(input longint pix, input longint freq);
        longint p;
        p = pix * freq;
        return (p * longint'(scale >> 12) + ((p * longint'(scale & 24'hFFF)) >> 12)) >> 12;
    endfunction

    function automatic t_dir dir_at(input longint row, input longint col);
        return t_dir'(grad_tbl[(row * 4 + col) * 3 +: 3]);
    endfunction

    function automatic longint octave_value(input longint px, input longint py,
                                            input longint freq);
        longint sx, sy, cx, cy, cx1, cy1, lx, ly;
        longint d00, d10, d01, d11, u, v;
        sx = cell_pos(px, freq);
        sy = cell_pos(py, freq);
        cx = (sx >> 16) % 4;
        cy = (sy >> 16) % 4;
        cx1 = (cx + 1) % 4;
        cy1 = (cy + 1) % 4;
        lx = sx & 16'hFFFF;
        ly = sy & 16'hFFFF;
        d00 = corner_dot(dir_at(cy, cx), lx, ly);
        d10 = corner_dot(dir_at(cy, cx1), lx - Q_ONE, ly);
        d01 = corner_dot(dir_at(cy1, cx), lx, ly - Q_ONE);
        d11 = corner_dot(dir_at(cy1, cx1), lx - Q_ONE, ly - Q_ONE);
        u = quintic(lx);
        v = quintic(ly);
        return blend(blend(d00, d10, u), blend(d01, d11, u), v);
    endfunction

    function automatic logic signed [15:0] fractal_noise(input longint px, input longint py);
        longint n, lac, freq, amp, total, sum, norm, r;
        n = longint'(octaves);
        lac = (lacun > 1024) ? 1024 : longint'(lacun);
        freq = Q_ONE;
        amp = Q_ONE;
        total = 0;
        sum = 0;
        if (n < 1) n = 1;
        if (n > 8) n = 8;
        for (int k = 0; k < n; k++) begin
            sum += octave_value(px, py, freq) * amp;
            total += amp;
            amp = (amp * longint'(persist)) >> 16;
            freq = (freq * lac) >> 8;
        end
        norm = sum / total;
        r = (norm * longint'(gain)) >>> 9;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    always @(posedge i_clk) begin
        logic signed [15:0] want;
        if (!i_rst_n) begin
            grad_tbl <= '0;
            scale    <= 24'd49152;
            octaves  <= 4'd8;
            persist  <= 16'd32768;
            lacun    <= 11'd512;
            gain     <= 13'd256;
            noise_fifo.delete();
            o_fail_count   <= 0;
            o_result_count <= 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                o_result_count <= o_result_count + 1;
                if (noise_fifo.size() == 0) begin
                    $display("%0t: unexpected noise_value %0d", $time, $signed(i_m_tdata));
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = noise_fifo.pop_front();
                    if (want !== $signed(i_m_tdata)) begin
                        $display("%0t: noise_value expected %0d actual %0d",
                                 $time, want, $signed(i_m_tdata));
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                noise_fifo.push_back(fractal_noise(longint'(i_s_tdata[9:0]),
                                                   longint'(i_s_tdata[19:10])));
            if (i_cfg_wen) begin
                case (i_cfg_idx)
                    CFG_GRAD:  grad_tbl <= i_cfg_data;
                    CFG_SCALE: scale    <= i_cfg_data[23:0];
                    CFG_OCT:   octaves  <= i_cfg_data[3:0];
                    CFG_PERS:  persist  <= i_cfg_data[15:0];
                    CFG_LAC:   lacun    <= i_cfg_data[10:0];
                    CFG_GAIN:  gain     <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_pending = noise_fifo.size();

endmodule

FILE: bench/testbench.sv
module testbench;
    import pfn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    typedef enum int {IDLE_SEND, IDLE_RECV, IDLE_NONE} t_idle_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [23:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;
    logic        i_cfg_wen = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [47:0] i_cfg_data = '0;

    int         fail_count;
    int         pending;
    int         result_count;
    t_idle_mode idle_mode = IDLE_NONE;
    int         hold_cycles = 0;
    int         pixels_sent = 0;
    int         config_sets = 0;

    always #4 i_clk = ~i_clk;

    perlin_fractal_noise_2d i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata),
        .i_cfg_wen(i_cfg_wen), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    noise_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .i_m_tdata(o_m_tdata),
        .i_cfg_wen(i_cfg_wen), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_m_tready  = 1'b0;
            hold_cycles = hold_cycles - 1;
        end else begin
            case (idle_mode)
                IDLE_SEND: i_m_tready = ($urandom_range(99) >= 53);
                IDLE_RECV: i_m_tready = ($urandom_range(99) >= 37);
                default:   i_m_tready = 1'b1;
            endcase
        end
    end

    task automatic send_pixel(input logic [9:0] px, input logic [9:0] py);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 37 : (idle_mode == IDLE_RECV) ? 53 : 0;
        while ($urandom_range(99) < gap_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = {4'd0, py, px};
        forever begin
            @(posedge i_clk);
            if (o_s_tready) break;
        end
        pixels_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
        i_cfg_wen  = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_wen  = 1'b0;
    endtask

    task automatic drain();
        i_s_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (130) @(negedge i_clk);
    endtask

    task automatic load_config(input logic [47:0] tbl, input logic [23:0] scl,
                               input logic [47:0] octs, input logic [47:0] pers,
                               input logic [47:0] lac, input logic [47:0] gn);
        write_reg(CFG_GRAD, tbl);
        write_reg(CFG_SCALE, {24'hA5A5A5, scl});
        write_reg(CFG_OCT, octs);
        write_reg(CFG_PERS, pers);
        write_reg(CFG_LAC, lac);
        write_reg(CFG_GAIN, gn);
        config_sets++;
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // defaults first, then every direction code and the field extremes
        send_pixel(10'd0, 10'd0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd1023, 10'd0);
        send_pixel(10'd0, 10'd1023);
        drain();
        load_config(48'o7654321076543210, 24'hFFFFFF, 48'd0, 48'd0, 48'd2047, 48'd4096);
        send_pixel(10'd512, 10'd511);
        send_pixel(10'd1023, 10'd1);
        send_pixel(10'd341, 10'd682);
        drain();
        load_config(48'o0123456701234567, 24'd3072, 48'd15, 48'd65535, 48'd256, 48'd8191);
        write_reg(CFG_SPARE_LO, 48'hFFFF_FFFF_FFFF);
        write_reg(CFG_SPARE_HI, 48'h0);
        send_pixel(10'd1023, 10'd1023);
        send_pixel(10'd17, 10'd900);
        send_pixel(10'd600, 10'd3);
        drain();
        load_config(rand48(), 24'd0, 48'd1, 48'hFFFF_FFFF_0000, 48'd0, 48'd0);
        send_pixel(10'd1023, 10'd700);
        send_pixel(10'd5, 10'd5);
        drain();
        load_config(rand48(), 24'd49152, 48'd8, 48'd32768, 48'd1024, 48'd4096);
        send_pixel(10'd777, 10'd222);
        send_pixel(10'd1000, 10'd1000);
        send_pixel(10'd0, 10'd512);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            idle_mode = t_idle_mode'(ph / 3);
            case (ph % 3)
                0: load_config(rand48(), 24'($urandom_range(24'hFFFFFF)),
                               48'($urandom_range(15)),
                               48'($urandom_range(65535)), 48'($urandom_range(2047)),
                               48'($urandom_range(8191)));
                1: load_config(rand48(), 24'($urandom_range(1024, 65536)),
                               48'($urandom_range(1, 8)),
                               48'($urandom_range(16384, 49152)),
                               48'($urandom_range(256, 1024)),
                               48'($urandom_range(128, 1024)));
                default: load_config(rand48(), 24'($urandom_range(4096, 786432)),
                                     48'($urandom_range(1, 4)), 48'($urandom_range(65535)),
                                     48'($urandom_range(256, 768)),
                                     48'($urandom_range(4096)));
            endcase
            if (ph == 4) hold_cycles = 400;
            repeat (82) send_pixel(10'($urandom_range(1023)), 10'($urandom_range(1023)));
            drain();
        end

        $display("Sent %0d pixels over %0d register settings, %0d noise values checked.",
                 pixels_sent, config_sets + 1, result_count);
        if (fail_count == 0) begin
            $display("** perlin_fractal_noise_2d: PASSED **");
        end else begin
            $display("** perlin_fractal_noise_2d: FAILED **");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("Timeout with %0d noise values outstanding.", pending);
        $display("** perlin_fractal_noise_2d: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/pfn_pkg.sv
hdl/pfn_octave.sv
hdl/pfn_div.sv
hdl/perlin_fractal_noise_2d.sv
hdl/pfn_checker.sv
bench/noise_checker.sv
bench/testbench.sv
